### hw/rtl/bhist_pkg.sv
`default_nettype none

package bhist_pkg;

  // Bin store geometry
  localparam int MAX_BINS = 256;
  localparam int BIN_W    = $clog2(MAX_BINS);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int X_W      = 32;
  localparam int SUM_W    = 56;
  localparam int CNT_W    = 32;
  localparam int NBIN_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 216;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_LOW       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]        CNT_MAX = '1;

  // One bin of the store
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0]        count;
  } bh_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic lookup;
    logic update;
  } bh_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } bh_sts_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] s,
    input logic signed [X_W-1:0]   v
  );
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(s) + (SUM_W+1)'(v);
    if (r[SUM_W] != r[SUM_W-1]) begin
      return r[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return r[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bhist_ctrl.sv
`default_nettype none

module bhist_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire bhist_pkg::bh_sts_t sts,
  output bhist_pkg::bh_ctl_t     ctl
);
  import bhist_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_BIN  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  // Issue one command per state
  always_comb begin
    ctl.load   = s_tvalid && s_tready;
    ctl.mul    = (state == ST_MUL);
    ctl.lookup = (state == ST_BIN);
    ctl.update = (state == ST_UPD) && sts.out_free;
  end

  // Advance through multiply, lookup and update; hold in update until the slot frees
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (ctl.load) state_next = ST_MUL;
      ST_MUL:  state_next = ST_BIN;
      ST_BIN:  state_next = ST_UPD;
      ST_UPD:  if (sts.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bhist_dp.sv
`default_nettype none

module bhist_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bhist_pkg::bh_ctl_t             ctl,
  output bhist_pkg::bh_sts_t                  sts,
  input  wire logic [bhist_pkg::IN_W-1:0]     s_tdata,
  input  wire logic [bhist_pkg::CMD_W-1:0]    s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [bhist_pkg::OUT_W-1:0]         m_tdata,
  output logic                                m_tuser,
  input  wire logic                           cfg_valid,
  input  wire logic [bhist_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bhist_pkg::X_W-1:0]      cfg_data
);
  import bhist_pkg::*;

  // Configuration
  logic signed [X_W-1:0] x_low;
  logic [X_W-1:0]        bin_scale;
  logic [NBIN_W-1:0]     bins_in_use;

  // Captured item
  logic [CMD_W-1:0]      cmd_q;
  logic signed [X_W-1:0] x_q;
  logic signed [X_W-1:0] y_q;
  logic [7:0]            rb_q;
  logic signed [X_W:0]   d_q;

  // Bin search
  logic [2*X_W-1:0]      prod_q;
  logic                  ok_q;
  logic [BIN_W-1:0]      bin_q;
  logic                  hit_q;
  logic [BIN_W-1:0]      addr;
  logic                  hit;

  // Bin store with per-bin valid bits
  bh_entry_t             mem [MAX_BINS];
  logic [MAX_BINS-1:0]   valid;
  bh_entry_t             rd_data;
  logic                  rd_valid;
  bh_entry_t             ent;
  bh_entry_t             ent_new;

  // Totals and result
  logic [CNT_W-1:0]      tot_in;
  logic [CNT_W-1:0]      tot_out;
  logic [CNT_W-1:0]      tot_in_next;
  logic [CNT_W-1:0]      tot_out_next;
  logic [7:0]            res_bin;
  logic                  res_in;
  bh_entry_t             res_ent;
  logic                  wr_en;

  // Write configuration registers; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low       <= '0;
      bin_scale   <= X_W'(65536);
      bins_in_use <= NBIN_W'(MAX_BINS);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_LOW:       x_low       <= cfg_data;
        REG_BIN_SCALE:   bin_scale   <= cfg_data;
        REG_BINS_IN_USE: bins_in_use <= cfg_data[NBIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the beat and the exact offset from the lower edge
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= s_tuser;
      x_q   <= s_tdata[31:0];
      y_q   <= s_tdata[63:32];
      rb_q  <= s_tdata[71:64];
      d_q   <= (X_W+1)'($signed(s_tdata[31:0])) - (X_W+1)'(x_low);
    end
  end

  // Scale the offset; a negative offset misses unless the scale is zero
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_q <= (2*X_W)'(d_q[X_W-1:0]) * (2*X_W)'(bin_scale);
      ok_q   <= !d_q[X_W] || (bin_scale == '0);
    end
  end

  // Pick the bin and decide whether it is in use
  always_comb begin
    addr = rb_q[BIN_W-1:0];
    hit  = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        addr = prod_q[X_W +: BIN_W];
        hit  = ok_q && (prod_q[2*X_W-1:X_W] < X_W'(bins_in_use))
                    && (prod_q[2*X_W-1:X_W] < X_W'(MAX_BINS));
      end
      CMD_READ: begin
        hit = (NBIN_W'(rb_q) < bins_in_use) && (X_W'(rb_q) < X_W'(MAX_BINS));
      end
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      bin_q    <= addr;
      hit_q    <= hit;
      rd_data  <= mem[addr];
      rd_valid <= valid[addr];
    end
  end

  // Bins never written since reset or clear read as zero
  always_comb begin
    ent = rd_valid ? rd_data : '0;
    ent_new.sum_x = sat_add(ent.sum_x, x_q);
    ent_new.sum_y = sat_add(ent.sum_y, y_q);
    ent_new.count = sat_inc(ent.count);
  end

  // Form the result and the next totals
  always_comb begin
    tot_in_next  = tot_in;
    tot_out_next = tot_out;
    res_bin      = '0;
    res_in       = 1'b0;
    res_ent      = '0;
    wr_en        = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        if (hit_q) begin
          wr_en       = 1'b1;
          tot_in_next = sat_inc(tot_in);
          res_bin     = 8'(bin_q);
          res_in      = 1'b1;
          res_ent     = ent_new;
        end else begin
          tot_out_next = sat_inc(tot_out);
        end
      end
      CMD_CLEAR: begin
        tot_in_next  = '0;
        tot_out_next = '0;
      end
      CMD_READ: begin
        res_bin = rb_q;
        if (hit_q) begin
          res_in  = 1'b1;
          res_ent = ent;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.update && wr_en) begin
      mem[bin_q] <= ent_new;
    end
  end

  // Mark written bins; clear drops every bin at once
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      tot_in  <= '0;
      tot_out <= '0;
    end else if (ctl.update) begin
      tot_in  <= tot_in_next;
      tot_out <= tot_out_next;
      if (cmd_q == CMD_CLEAR) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[bin_q] <= 1'b1;
      end
    end
  end

  // Output register
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      m_tuser <= res_in;
      m_tdata <= {tot_out_next, tot_in_next, res_ent.count,
                  res_ent.sum_y, res_ent.sum_x, res_bin};
    end
  end

  a_upd_free: assert property (@(posedge clk) disable iff (rst)
    ctl.update |-> sts.out_free) else $error("update with output slot busy");

  a_upd_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.update |=> m_tvalid) else $error("result not presented after update");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.update && (cmd_q == CMD_CLEAR) |=> (tot_in == '0) && (tot_out == '0) && (valid == '0))
    else $error("clear left state behind");

  a_mark: assert property (@(posedge clk) disable iff (rst)
    ctl.update && wr_en |=> valid[$past(bin_q)])
    else $error("written bin not marked");

endmodule

`default_nettype wire

### hw/rtl/binned_histogram_with_sums_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    s_tdata, s_tuser (command)
// m_        out        m_tvalid/m_tready    m_tdata, m_tuser (in_range)
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each beat passes through accept, scale multiply, bin store read and update.
// The 32x32 multiply and the registered store read each have a step of their own.
// The update waits while the output register still holds an untaken result.
// Reset clears the per-bin valid bits at once; no clearing pass is needed.
// A clear command likewise goes through the same steps as any other beat.
module binned_histogram_with_sums_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [31:0] sample_x, [63:32] sample_y, [71:64] read_bin
  input  wire logic [bhist_pkg::IN_W-1:0]      s_tdata,
  // [1:0] command
  input  wire logic [bhist_pkg::CMD_W-1:0]     s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [7:0] bin_index, [63:8] bin_sum_x, [119:64] bin_sum_y, [151:120] bin_count,
  // [183:152] total_in_range, [215:184] total_out_of_range
  output logic [bhist_pkg::OUT_W-1:0]          m_tdata,
  // [0] in_range
  output logic                                 m_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bhist_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bhist_pkg::X_W-1:0]       cfg_data
);
  import bhist_pkg::*;

  bh_ctl_t ctl;
  bh_sts_t sts;

  assign cfg_ready = 1'b1;

  bhist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bhist_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

### tb/binned_histogram_with_sums_top_tb.sv
`timescale 1ns / 100ps

module binned_histogram_with_sums_top_tb;
  import bhist_pkg::*;

  // Command code with no effect on the store
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int STALL_PCT  = 33;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_GAP  = 8;

  // One result beat, unpacked
  typedef struct packed {
    logic [BIN_W-1:0]        bin_index;
    logic                    in_range;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0]        count;
    logic [CNT_W-1:0]        total_in;
    logic [CNT_W-1:0]        total_out;
  } bin_report_t;

  // Histogram predictor and result scoreboard
  class hist_scoreboard;
    logic signed [SUM_W-1:0] x_sums [MAX_BINS];
    logic signed [SUM_W-1:0] y_sums [MAX_BINS];
    logic [CNT_W-1:0]        hits [MAX_BINS];
    logic [CNT_W-1:0]        hits_total;
    logic [CNT_W-1:0]        misses_total;
    logic signed [X_W-1:0]   lower_edge;
    logic [X_W-1:0]          scale;
    logic [NBIN_W-1:0]       bin_limit;
    bin_report_t             pending [$];
    int errors, checked, n_hit, n_miss, n_read, n_clear, n_nop;

    function new();
      for (int i = 0; i < MAX_BINS; i++) begin
        x_sums[i] = '0;
        y_sums[i] = '0;
        hits[i]   = '0;
      end
      hits_total   = '0;
      misses_total = '0;
      lower_edge   = '0;
      scale        = 32'h0001_0000;
      bin_limit    = 9'd256;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [X_W-1:0] val);
      case (idx)
        REG_X_LOW:       lower_edge = val;
        REG_BIN_SCALE:   scale      = val;
        REG_BINS_IN_USE: bin_limit  = val[NBIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [SUM_W-1:0] sum_add(logic signed [SUM_W-1:0] s,
                                              logic signed [X_W-1:0] v);
      longint t;
      t = longint'(s) + longint'(v);
      if (t > 64'sh007F_FFFF_FFFF_FFFF) return SUM_MAX;
      if (t < -64'sh0080_0000_0000_0000) return SUM_MIN;
      return t[SUM_W-1:0];
    endfunction

    function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    // Work out the result of one accepted beat and queue it
    function void note_input(logic [CMD_W-1:0] cmd, logic signed [X_W-1:0] x,
                             logic signed [X_W-1:0] y, logic [BIN_W-1:0] rb);
      bin_report_t r;
      logic signed [X_W:0] span;
      logic [63:0] product;
      logic [31:0] bin;
      logic [BIN_W-1:0] b;
      logic hit;
      int unsigned nb;
      r   = '0;
      nb  = (bin_limit > MAX_BINS) ? MAX_BINS : bin_limit;
      bin = '0;
      hit = 1'b1;
      case (cmd)
        CMD_ADD: begin
          span = $signed({x[X_W-1], x}) - $signed({lower_edge[X_W-1], lower_edge});
          if (scale != '0) begin
            if (span < 0) begin
              hit = 1'b0;
            end else begin
              product = {32'b0, span[X_W-1:0]} * {32'b0, scale};
              bin = product[63:32];
            end
          end
          b = bin[BIN_W-1:0];
          if (hit && bin < nb) begin
            x_sums[b]   = sum_add(x_sums[b], x);
            y_sums[b]   = sum_add(y_sums[b], y);
            hits[b]     = count_up(hits[b]);
            hits_total  = count_up(hits_total);
            r.bin_index = b;
            r.in_range  = 1'b1;
            r.sum_x     = x_sums[b];
            r.sum_y     = y_sums[b];
            r.count     = hits[b];
            n_hit++;
          end else begin
            misses_total = count_up(misses_total);
            n_miss++;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < MAX_BINS; i++) begin
            x_sums[i] = '0;
            y_sums[i] = '0;
            hits[i]   = '0;
          end
          hits_total   = '0;
          misses_total = '0;
          n_clear++;
        end
        CMD_READ: begin
          r.bin_index = rb;
          if (rb < nb) begin
            r.in_range = 1'b1;
            r.sum_x    = x_sums[rb];
            r.sum_y    = y_sums[rb];
            r.count    = hits[rb];
          end
          n_read++;
        end
        default: n_nop++;
      endcase
      r.total_in  = hits_total;
      r.total_out = misses_total;
      pending.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH result %0d: %s", $realtime, checked, what);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Compare a result beat with the oldest expectation
    task check(bin_report_t got);
      bin_report_t want;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = pending.pop_front();
        compare_field("bin_index", 64'(got.bin_index), 64'(want.bin_index));
        compare_field("in_range", 64'(got.in_range), 64'(want.in_range));
        compare_field("bin_sum_x", 64'(unsigned'(got.sum_x)), 64'(unsigned'(want.sum_x)));
        compare_field("bin_sum_y", 64'(unsigned'(got.sum_y)), 64'(unsigned'(want.sum_y)));
        compare_field("bin_count", 64'(got.count), 64'(want.count));
        compare_field("total_in_range", 64'(got.total_in), 64'(want.total_in));
        compare_field("total_out_of_range", 64'(got.total_out), 64'(want.total_out));
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = CMD_ADD;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_X_LOW;
  logic [X_W-1:0] cfg_data = '0;

  hist_scoreboard sb = new();
  logic idling = 1'b1;
  int settings = 0;
  int quiet_cycles = 0;

  binned_histogram_with_sums_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Take result beats; while idling is set, stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        sb.check('{bin_index: m_tdata[7:0], in_range: m_tuser,
                   sum_x: m_tdata[63:8], sum_y: m_tdata[119:64],
                   count: m_tdata[151:120], total_in: m_tdata[183:152],
                   total_out: m_tdata[215:184]});
      end
      m_tready <= idling ? ($urandom_range(0, 99) >= STALL_PCT) : 1'b1;
    end
  end

  // Abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results pending",
               quiet_cycles, sb.pending.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Drive one command beat, with an optional gap ahead of it
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [X_W-1:0] x, logic [X_W-1:0] y,
                           logic [BIN_W-1:0] rb);
    if (idling && $urandom_range(0, 99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < STALL_PCT);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {rb, y, x};
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, x, y, rb);
  endtask

  // Hold off until every expected result is out, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Write all three registers back to back while the block is idle
  task automatic write_config(logic [X_W-1:0] lo, logic [X_W-1:0] sc, logic [NBIN_W-1:0] nb);
    logic [X_W-1:0] vals [3];
    vals[0] = lo;
    vals[1] = sc;
    vals[2] = X_W'(nb);
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_register(CFG_IDX_W'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Pick an abscissa, mostly aimed at a bin near the used range
  function automatic logic [X_W-1:0] pick_x(logic signed [X_W-1:0] lo, logic [X_W-1:0] sc,
                                           int unsigned nb);
    longint offs, xw;
    int unsigned target;
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: offs = longint'($urandom_range(0, 64)) - 32;
      default: begin
        target = $urandom_range(0, nb + 3);
        if (sc == '0) offs = longint'($urandom_range(0, 1000));
        else offs = ((longint'(target) << 32) + longint'($urandom())) / longint'({32'b0, sc});
      end
    endcase
    xw = longint'(lo) + offs;
    if (xw > 64'sh7FFF_FFFF || xw < -64'sh8000_0000) return $urandom();
    return xw[X_W-1:0];
  endfunction

  function automatic logic [X_W-1:0] pick_y();
    case ($urandom_range(0, 19))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [X_W-1:0] lo, sc;
    logic [NBIN_W-1:0] nb;
    int unsigned pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: bin edges, values just outside, extremes, read, clear, nop
    send_item(CMD_ADD, 32'h0000_0000, 32'h7FFF_FFFF, 8'h00);
    send_item(CMD_ADD, 32'h0000_FFFF, 32'h8000_0000, 8'hFF);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 8'h00);
    send_item(CMD_ADD, 32'h00FF_FFFF, 32'hFFFF_FFFF, 8'h00);
    send_item(CMD_ADD, 32'h0100_0000, 32'h1234_5678, 8'h00);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00);
    send_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 8'h00);
    send_item(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
    send_item(CMD_READ, 32'h0, 32'h0, 8'hFF);
    send_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_READ, 32'h0, 32'h0, 8'h00);
    send_item(CMD_ADD, 32'h0080_1234, 32'h1234_5678, 8'hAA);

    // Zero scale sends everything to the single bin
    write_config(32'h8000_0000, 32'h0, 9'd1);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00);
    send_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 8'h00);
    send_item(CMD_READ, 32'h0, 32'h0, 8'h01);
    send_item(CMD_READ, 32'h0, 32'h0, 8'h00);

    // Top edge, widest scale, bin count above the store size
    write_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd511);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h5555_AAAA, 8'h00);
    send_item(CMD_ADD, 32'h7FFF_FFFE, 32'hAAAA_5555, 8'h00);
    send_item(CMD_READ, 32'h0, 32'h0, 8'hFF);

    // No bins at all
    write_config(32'h0, 32'h0001_0000, 9'd0);
    send_item(CMD_ADD, 32'h0000_0005, 32'h0000_0007, 8'h00);
    send_item(CMD_READ, 32'h0, 32'h0, 8'h00);

    // Bottom edge, widest scale: first bin, last bin and one past it
    write_config(32'h8000_0000, 32'hFFFF_FFFF, 9'd256);
    send_item(CMD_ADD, 32'h8000_0000, 32'h0000_0003, 8'h00);
    send_item(CMD_ADD, 32'h8000_0100, 32'h0000_0004, 8'h00);
    send_item(CMD_ADD, 32'h8000_0101, 32'h0000_0005, 8'h00);

    // Random settings, each with a burst of mostly add commands
    for (int phase = 0; phase < 5; phase++) begin
      lo = $urandom();
      case ($urandom_range(0, 5))
        0: sc = 32'h0;
        1: sc = $urandom();
        default: sc = (32'h1 << $urandom_range(12, 22)) | $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 7))
        0: nb = 9'd0;
        1: nb = NBIN_W'($urandom_range(257, 511));
        default: nb = NBIN_W'($urandom_range(1, 256));
      endcase
      if (phase == 0) sc = 32'h0001_0000 << $urandom_range(0, 4);
      write_config(lo, sc, nb);
      idling = (phase != 2);
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 82)
          send_item(CMD_ADD, pick_x(lo, sc, (nb > MAX_BINS) ? MAX_BINS : nb), pick_y(),
                    BIN_W'($urandom()));
        else if (pick < 95)
          send_item(CMD_READ, $urandom(), $urandom(), BIN_W'($urandom()));
        else if (pick < 99)
          send_item(CMD_NOP, $urandom(), $urandom(), BIN_W'($urandom()));
        else
          send_item(CMD_CLEAR, $urandom(), $urandom(), BIN_W'($urandom()));
      end
      idling = 1'b1;
    end

    settle();
    $display("Checked %0d results over %0d register settings", sb.checked, settings);
    $display("Samples in a bin %0d, outside %0d; reads %0d, clears %0d, ignored %0d",
             sb.n_hit, sb.n_miss, sb.n_read, sb.n_clear, sb.n_nop);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/bhist_pkg.sv
hw/rtl/bhist_ctrl.sv
hw/rtl/bhist_dp.sv
hw/rtl/binned_histogram_with_sums_top.sv
tb/binned_histogram_with_sums_top_tb.sv
